// ===== rtl/hpms_pkg.sv =====
// package: types, codes and reset values for the heat pump mode sequencer
`default_nettype none

package hpms_pkg;

    localparam int STATUS_W = 16;
    localparam int DWELL_W  = 24;
    localparam int POST_W   = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        MODE_ERROR     = 3'd0,
        MODE_DEFROST   = 3'd1,
        MODE_POST_RUN  = 3'd2,
        MODE_COOLING   = 3'd3,
        MODE_HEATING   = 3'd4,
        MODE_HOT_WATER = 3'd5,
        MODE_STANDBY   = 3'd6
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_READ_ERROR_CODE = 3'd0,
        CFG_DEFROST_MASK    = 3'd1,
        CFG_COMPRESSOR_MASK = 3'd2,
        CFG_COOLING_MASK    = 3'd3,
        CFG_HEATING_MASK    = 3'd4,
        CFG_HOT_WATER_MASK  = 3'd5,
        CFG_MIN_DWELL_TICKS = 3'd6,
        CFG_POST_RUN_TICKS  = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        ACTION_TICK = 1'b0,
        ACTION_POLL = 1'b1
    } action_t;

    localparam logic [STATUS_W-1:0] RST_READ_ERROR_CODE = 16'd65535;
    localparam logic [STATUS_W-1:0] RST_DEFROST_MASK    = 16'd1;
    localparam logic [STATUS_W-1:0] RST_COMPRESSOR_MASK = 16'd2;
    localparam logic [STATUS_W-1:0] RST_COOLING_MASK    = 16'd4;
    localparam logic [STATUS_W-1:0] RST_HEATING_MASK    = 16'd8;
    localparam logic [STATUS_W-1:0] RST_HOT_WATER_MASK  = 16'd16;
    localparam logic [DWELL_W-1:0]  RST_MIN_DWELL_TICKS = 24'd30000;
    localparam logic [POST_W-1:0]   RST_POST_RUN_TICKS  = 32'd300000;

    typedef struct packed {
        logic                action;
        logic [STATUS_W-1:0] status_word;
    } hpms_in_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       mode_changed;
    } hpms_out_t;

endpackage

`default_nettype wire

// ===== rtl/heat_pump_mode_sequencer_top.sv =====
// heat pump mode sequencer: classifies operating mode from ticks and status polls
//
// request channel item/item_valid/item_stall: each request is a one millisecond
// tick or a status poll; every request gives exactly one result on res/res_valid/
// res_stall, in order, carrying the mode after that request and a changed flag
// a request in the input register moves to the result register when that is
// empty or being taken; throughput: one request per cycle while the receiver
// does not stall; an input and a result register hold one request each, and the
// mode, dwell and post-run registers are updated when a request moves between them
// when the receiver stalls, the result holds; the input register keeps one more
// request, then item_stall rises until the result is taken
// config channel cfg_valid/cfg_ready/cfg_index/cfg_data is always ready; write
// only while no request is in flight
// reset: mode standby, dwell and post-run counters zero, registers at defaults,
// both pipeline registers empty
`default_nettype none

module heat_pump_mode_sequencer_top
    import hpms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire hpms_in_t             item,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output hpms_out_t                 res,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [STATUS_W-1:0] read_error_code_reg;
    logic [STATUS_W-1:0] defrost_mask_reg;
    logic [STATUS_W-1:0] compressor_mask_reg;
    logic [STATUS_W-1:0] cooling_mask_reg;
    logic [STATUS_W-1:0] heating_mask_reg;
    logic [STATUS_W-1:0] hot_water_mask_reg;
    logic [DWELL_W-1:0]  min_dwell_ticks_reg;
    logic [POST_W-1:0]   post_run_ticks_reg;

    logic                item_valid_reg;
    hpms_in_t            item_reg;
    logic                res_valid_reg;
    hpms_out_t           res_reg;

    mode_t               mode_reg;
    mode_t               mode_next;
    logic [DWELL_W-1:0]  dwell_reg;
    logic [DWELL_W-1:0]  dwell_next;
    logic [POST_W-1:0]   post_run_reg;
    logic [POST_W-1:0]   post_run_next;
    mode_t               poll_mode;
    logic [POST_W-1:0]   poll_post_run;

    logic                advance;
    logic                load;
    logic [STATUS_W-1:0] st;
    logic                comp;
    logic                cool;
    logic                heat;
    logic                hot;

    assign advance    = item_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = item_valid_reg && !advance;
    assign load       = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign st   = item_reg.status_word;
    assign comp = |(st & compressor_mask_reg);
    assign cool = |(st & cooling_mask_reg);
    assign heat = |(st & heating_mask_reg);
    assign hot  = |(st & hot_water_mask_reg);

    // poll classification, rule order decides
    always_comb
    begin
        poll_mode     = mode_reg;
        poll_post_run = post_run_reg;
        priority if (st == read_error_code_reg)
        begin
            poll_mode     = MODE_ERROR;
            poll_post_run = '0;
        end
        else if (|(st & defrost_mask_reg))
        begin
            poll_mode     = MODE_DEFROST;
            poll_post_run = '0;
        end
        else if (dwell_reg < min_dwell_ticks_reg)
        begin
            poll_mode = mode_reg;
        end
        else if (!comp && mode_reg == MODE_HOT_WATER)
        begin
            poll_mode     = MODE_POST_RUN;
            poll_post_run = post_run_ticks_reg;
        end
        else if (mode_reg == MODE_POST_RUN)
        begin
            priority if (cool)
            begin
                poll_mode     = MODE_COOLING;
                poll_post_run = '0;
            end
            else if (heat)
            begin
                poll_mode     = MODE_HEATING;
                poll_post_run = '0;
            end
            else if (hot)
            begin
                poll_mode     = MODE_HOT_WATER;
                poll_post_run = '0;
            end
            else if (post_run_reg != '0)
            begin
                poll_mode = MODE_POST_RUN;
            end
            else
            begin
                poll_mode = MODE_STANDBY;
            end
        end
        else if (!comp)
        begin
            poll_mode = MODE_STANDBY;
        end
        else if (cool)
        begin
            poll_mode = MODE_COOLING;
        end
        else if (heat)
        begin
            poll_mode = MODE_HEATING;
        end
        else if (hot)
        begin
            poll_mode = MODE_HOT_WATER;
        end
        else
        begin
            poll_mode = MODE_STANDBY;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        dwell_next    = dwell_reg;
        post_run_next = post_run_reg;
        if (item_reg.action == ACTION_TICK)
        begin
            if (dwell_reg != '1)
                dwell_next = dwell_reg + 1'b1;
            if (post_run_reg != '0)
                post_run_next = post_run_reg - 1'b1;
        end
        else
        begin
            mode_next     = poll_mode;
            post_run_next = poll_post_run;
            if (poll_mode != mode_reg)
                dwell_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_error_code_reg <= RST_READ_ERROR_CODE;
            defrost_mask_reg    <= RST_DEFROST_MASK;
            compressor_mask_reg <= RST_COMPRESSOR_MASK;
            cooling_mask_reg    <= RST_COOLING_MASK;
            heating_mask_reg    <= RST_HEATING_MASK;
            hot_water_mask_reg  <= RST_HOT_WATER_MASK;
            min_dwell_ticks_reg <= RST_MIN_DWELL_TICKS;
            post_run_ticks_reg  <= RST_POST_RUN_TICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_READ_ERROR_CODE: read_error_code_reg <= cfg_data[STATUS_W-1:0];
                CFG_DEFROST_MASK:    defrost_mask_reg    <= cfg_data[STATUS_W-1:0];
                CFG_COMPRESSOR_MASK: compressor_mask_reg <= cfg_data[STATUS_W-1:0];
                CFG_COOLING_MASK:    cooling_mask_reg    <= cfg_data[STATUS_W-1:0];
                CFG_HEATING_MASK:    heating_mask_reg    <= cfg_data[STATUS_W-1:0];
                CFG_HOT_WATER_MASK:  hot_water_mask_reg  <= cfg_data[STATUS_W-1:0];
                CFG_MIN_DWELL_TICKS: min_dwell_ticks_reg <= cfg_data[DWELL_W-1:0];
                CFG_POST_RUN_TICKS:  post_run_ticks_reg  <= cfg_data[POST_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            mode_reg       <= MODE_STANDBY;
            dwell_reg      <= '0;
            post_run_reg   <= '0;
        end
        else
        begin
            if (load)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;

            if (advance)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;

            if (advance)
            begin
                mode_reg     <= mode_next;
                dwell_reg    <= dwell_next;
                post_run_reg <= post_run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item;
        if (advance)
        begin
            res_reg.mode         <= mode_next;
            res_reg.mode_changed <= (item_reg.action == ACTION_POLL) && (poll_mode != mode_reg);
        end
    end

    a_post_run_only_in_post_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        post_run_reg != '0 |-> mode_reg == MODE_POST_RUN
    ) else $error("post-run countdown active outside post-run mode");

    a_change_clears_dwell: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && item_reg.action == ACTION_POLL && poll_mode != mode_reg
            |=> dwell_reg == '0
    ) else $error("mode change did not clear dwell counter");

    a_result_tracks_mode: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg && res_reg.mode == mode_reg
    ) else $error("result mode differs from current mode");

endmodule

`default_nettype wire
